@@ design/clock_alarm_set_controller_defines.svh @@
// Assertion helpers for the controller's assertions.
`ifndef CLOCK_ALARM_SET_CONTROLLER_DEFINES_SVH
`define CLOCK_ALARM_SET_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLKAS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clkas: implication check failed");

// Next-cycle implication, checked outside reset.
`define CLKAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clkas: next-cycle check failed");

`endif

@@ design/clkas_pkg.sv @@
package clkas_pkg;

   typedef enum logic [1:0] {
      ModeNormal = 2'd0,
      ModeTime   = 2'd1,
      ModeAlarm  = 2'd2
   } mode_type;

   localparam logic [2:0] ActPoll  = 3'd0;
   localparam logic [2:0] ActUp    = 3'd1;
   localparam logic [2:0] ActDown  = 3'd2;
   localparam logic [2:0] ActNext  = 3'd3;
   localparam logic [2:0] ActTime  = 3'd4;
   localparam logic [2:0] ActAlarm = 3'd5;

   // field select codes in time setting
   localparam logic [2:0] FldHour    = 3'd1;
   localparam logic [2:0] FldMinute  = 3'd2;
   localparam logic [2:0] FldSecond  = 3'd3;
   localparam logic [2:0] FldWeekday = 3'd4;
   localparam logic [2:0] FldDay     = 3'd5;
   localparam logic [2:0] FldMonth   = 3'd6;
   localparam logic [2:0] FldYear    = 3'd7;
   localparam logic [2:0] FldNone    = 3'd0;

   // field select codes in alarm setting
   localparam logic [2:0] AlmEnable = 3'd1;
   localparam logic [2:0] AlmHour   = 3'd2;
   localparam logic [2:0] AlmMinute = 3'd3;
   localparam logic [2:0] AlmSecond = 3'd4;

   localparam logic [2:0] TimeLastField  = FldYear;
   localparam logic [2:0] AlarmLastField = AlmSecond;

   localparam logic [6:0] HourMax    = 7'd23;
   localparam logic [6:0] MinSecMax  = 7'd59;
   localparam logic [6:0] WeekdayMax = 7'd7;
   localparam logic [6:0] DayMax     = 7'd31;
   localparam logic [6:0] MonthMax   = 7'd12;
   localparam logic [6:0] YearMax    = 7'd99;
   localparam logic [6:0] ZeroMin    = 7'd0;
   localparam logic [6:0] OneMin     = 7'd1;

   typedef struct packed {
      logic [2:0] action;
      logic [4:0] rtc_hour;
      logic [5:0] rtc_minute;
      logic [5:0] rtc_second;
      logic [2:0] rtc_weekday;
      logic [4:0] rtc_day;
      logic [3:0] rtc_month;
      logic [6:0] rtc_year;
   } item_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] weekday;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } date_time_type;

   typedef struct packed {
      logic       buzzer;
      logic [1:0] mode_now;
      logic [2:0] blank_field;
      logic       write_rtc;
      logic       alarm_on;
      logic [4:0] hour_shown;
      logic [5:0] minute_shown;
      logic [5:0] second_shown;
      logic [2:0] weekday_shown;
      logic [4:0] day_shown;
      logic [3:0] month_shown;
      logic [6:0] year_shown;
   } result_type;

   // Step a field up or down with wraparound; up from above top yields bottom.
   function automatic logic [6:0] step_wrap(logic [6:0] value, logic up,
                                            logic [6:0] bottom, logic [6:0] top);
      logic [6:0] res;
      if (up) begin
         res = (value < top) ? value + 7'd1 : bottom;
      end else begin
         res = (value > bottom) ? value - 7'd1 : top;
      end
      return res;
   endfunction

endpackage

@@ design/clkas_core.sv @@
module clkas_core #(
   parameter int unsigned BLINK_HALF = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  clkas_pkg::item_type    item,
   output clkas_pkg::result_type  result
);

   localparam logic [5:0] BlinkHalf   = 6'(BLINK_HALF);
   localparam logic [5:0] BlinkPeriod = 6'(2 * BLINK_HALF);

   clkas_pkg::mode_type      mode_ff, mode_in;
   logic [2:0]               field_ff, field_in;
   logic [5:0]               blink_ff, blink_in;
   clkas_pkg::date_time_type edit_ff, edit_in;
   logic [4:0]               alarm_hour_ff, alarm_hour_in;
   logic [5:0]               alarm_minute_ff, alarm_minute_in;
   logic [5:0]               alarm_second_ff, alarm_second_in;
   logic                     alarm_enable_ff, alarm_enable_in;
   logic                     ringing_ff, ringing_in;

   logic [5:0]               blink_inc;
   logic                     step_up;
   logic                     alarm_match;
   logic                     write_pulse;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= clkas_pkg::ModeNormal;
         field_ff        <= clkas_pkg::FldHour;
         blink_ff        <= '0;
         edit_ff         <= '{hour: 5'd0, minute: 6'd0, second: 6'd0, weekday: 3'd1,
                              day: 5'd1, month: 4'd1, year: 7'd0};
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
         alarm_second_ff <= '0;
         alarm_enable_ff <= 1'b0;
         ringing_ff      <= 1'b0;
      end else if (step_en) begin
         mode_ff         <= mode_in;
         field_ff        <= field_in;
         blink_ff        <= blink_in;
         edit_ff         <= edit_in;
         alarm_hour_ff   <= alarm_hour_in;
         alarm_minute_ff <= alarm_minute_in;
         alarm_second_ff <= alarm_second_in;
         alarm_enable_ff <= alarm_enable_in;
         ringing_ff      <= ringing_in;
      end
   end

   // advance the blink counter, wrapping at the full period
   always_comb begin
      blink_inc = blink_ff + 6'd1;
      if (blink_inc >= BlinkPeriod) begin
         blink_inc = 6'd0;
      end
   end

   assign step_up     = (item.action == clkas_pkg::ActUp);
   assign alarm_match = alarm_enable_ff && (item.rtc_hour == alarm_hour_ff)
                        && (item.rtc_minute == alarm_minute_ff)
                        && (item.rtc_second == alarm_second_ff);

   always_comb begin
      mode_in         = mode_ff;
      field_in        = field_ff;
      blink_in        = blink_ff;
      edit_in         = edit_ff;
      alarm_hour_in   = alarm_hour_ff;
      alarm_minute_in = alarm_minute_ff;
      alarm_second_in = alarm_second_ff;
      alarm_enable_in = alarm_enable_ff;
      ringing_in      = ringing_ff;
      write_pulse     = 1'b0;

      unique case (mode_ff)
         clkas_pkg::ModeTime: begin
            blink_in = blink_inc;
            case (item.action) inside
               clkas_pkg::ActUp, clkas_pkg::ActDown: begin
                  blink_in = 6'd0;
                  case (field_ff)
                     clkas_pkg::FldHour: edit_in.hour = 5'(clkas_pkg::step_wrap(
                        7'(edit_ff.hour), step_up, clkas_pkg::ZeroMin, clkas_pkg::HourMax));
                     clkas_pkg::FldMinute: edit_in.minute = 6'(clkas_pkg::step_wrap(
                        7'(edit_ff.minute), step_up, clkas_pkg::ZeroMin, clkas_pkg::MinSecMax));
                     clkas_pkg::FldSecond: edit_in.second = 6'(clkas_pkg::step_wrap(
                        7'(edit_ff.second), step_up, clkas_pkg::ZeroMin, clkas_pkg::MinSecMax));
                     clkas_pkg::FldWeekday: edit_in.weekday = 3'(clkas_pkg::step_wrap(
                        7'(edit_ff.weekday), step_up, clkas_pkg::OneMin, clkas_pkg::WeekdayMax));
                     clkas_pkg::FldDay: edit_in.day = 5'(clkas_pkg::step_wrap(
                        7'(edit_ff.day), step_up, clkas_pkg::OneMin, clkas_pkg::DayMax));
                     clkas_pkg::FldMonth: edit_in.month = 4'(clkas_pkg::step_wrap(
                        7'(edit_ff.month), step_up, clkas_pkg::OneMin, clkas_pkg::MonthMax));
                     clkas_pkg::FldYear: edit_in.year = clkas_pkg::step_wrap(
                        edit_ff.year, step_up, clkas_pkg::ZeroMin, clkas_pkg::YearMax);
                     default: ;
                  endcase
               end
               clkas_pkg::ActNext: begin
                  blink_in = BlinkHalf;
                  field_in = (field_ff >= clkas_pkg::TimeLastField) ? clkas_pkg::FldHour
                                                                    : field_ff + 3'd1;
               end
               clkas_pkg::ActTime: begin
                  mode_in     = clkas_pkg::ModeNormal;
                  write_pulse = 1'b1;
               end
               default: ;
            endcase
         end
         clkas_pkg::ModeAlarm: begin
            blink_in = blink_inc;
            case (item.action) inside
               clkas_pkg::ActUp, clkas_pkg::ActDown: begin
                  blink_in = 6'd0;
                  case (field_ff)
                     clkas_pkg::AlmEnable: alarm_enable_in = ~alarm_enable_ff;
                     clkas_pkg::AlmHour: alarm_hour_in = 5'(clkas_pkg::step_wrap(
                        7'(alarm_hour_ff), step_up, clkas_pkg::ZeroMin, clkas_pkg::HourMax));
                     clkas_pkg::AlmMinute: alarm_minute_in = 6'(clkas_pkg::step_wrap(
                        7'(alarm_minute_ff), step_up, clkas_pkg::ZeroMin, clkas_pkg::MinSecMax));
                     clkas_pkg::AlmSecond: alarm_second_in = 6'(clkas_pkg::step_wrap(
                        7'(alarm_second_ff), step_up, clkas_pkg::ZeroMin, clkas_pkg::MinSecMax));
                     default: ;
                  endcase
               end
               clkas_pkg::ActNext: begin
                  blink_in = BlinkHalf;
                  field_in = (field_ff >= clkas_pkg::AlarmLastField) ? clkas_pkg::AlmEnable
                                                                     : field_ff + 3'd1;
               end
               clkas_pkg::ActAlarm: mode_in = clkas_pkg::ModeNormal;
               default: ;
            endcase
         end
         clkas_pkg::ModeNormal: begin
            // copy the clock and compare before the button is handled
            edit_in = '{hour: item.rtc_hour, minute: item.rtc_minute,
                        second: item.rtc_second, weekday: item.rtc_weekday,
                        day: item.rtc_day, month: item.rtc_month, year: item.rtc_year};
            if (alarm_match) begin
               ringing_in = 1'b1;
            end
            if (item.action == clkas_pkg::ActTime) begin
               mode_in  = clkas_pkg::ModeTime;
               field_in = clkas_pkg::FldHour;
               blink_in = 6'd0;
            end else if (item.action == clkas_pkg::ActAlarm) begin
               if (ringing_in) begin
                  ringing_in = 1'b0;
               end else begin
                  mode_in  = clkas_pkg::ModeAlarm;
                  field_in = clkas_pkg::AlmEnable;
                  blink_in = 6'd0;
               end
            end
         end
         default: mode_in = clkas_pkg::ModeNormal;
      endcase
   end

   always_comb begin
      result.buzzer      = ringing_in;
      result.mode_now    = mode_in;
      result.blank_field = ((mode_in != clkas_pkg::ModeNormal) && (blink_in >= BlinkHalf))
                           ? field_in : clkas_pkg::FldNone;
      result.write_rtc   = write_pulse;
      result.alarm_on    = alarm_enable_in;
      if (mode_in == clkas_pkg::ModeAlarm) begin
         result.hour_shown   = alarm_hour_in;
         result.minute_shown = alarm_minute_in;
         result.second_shown = alarm_second_in;
      end else begin
         result.hour_shown   = edit_in.hour;
         result.minute_shown = edit_in.minute;
         result.second_shown = edit_in.second;
      end
      result.weekday_shown = edit_in.weekday;
      result.day_shown     = edit_in.day;
      result.month_shown   = edit_in.month;
      result.year_shown    = edit_in.year;
   end

endmodule

@@ design/clock_alarm_set_controller.sv @@
// Alarm clock set controller. Takes one word per cycle (a poll pass or a button event
// with the current clock fields) and returns one result word per input word: the word
// is held in the input register, then the mode, blink and field logic writes the result
// register and updates the controller state in the same edge. Throughput is one word
// per cycle while the result side does not stall; a stalled result holds and the input
// register fills before req_stall rises. BLINK_HALF sets the number of setting-mode
// words for each half of the blink period.
`include "clock_alarm_set_controller_defines.svh"

module clock_alarm_set_controller #(
   parameter int unsigned BLINK_HALF = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [4:0] req_rtc_hour,
   input  logic [5:0] req_rtc_minute,
   input  logic [5:0] req_rtc_second,
   input  logic [2:0] req_rtc_weekday,
   input  logic [4:0] req_rtc_day,
   input  logic [3:0] req_rtc_month,
   input  logic [6:0] req_rtc_year,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_buzzer,
   output logic [1:0] rsp_mode_now,
   output logic [2:0] rsp_blank_field,
   output logic       rsp_write_rtc,
   output logic       rsp_alarm_on,
   output logic [4:0] rsp_hour_shown,
   output logic [5:0] rsp_minute_shown,
   output logic [5:0] rsp_second_shown,
   output logic [2:0] rsp_weekday_shown,
   output logic [4:0] rsp_day_shown,
   output logic [3:0] rsp_month_shown,
   output logic [6:0] rsp_year_shown
);

   logic                  s1_valid_ff, s1_valid_in;
   clkas_pkg::item_type   s1_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   clkas_pkg::result_type rsp_ff;
   clkas_pkg::result_type core_result;
   logic                  advance;
   logic                  s1_load;
   logic                  step_en;

   // the result register is free when empty or being taken this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || advance;
   assign step_en   = s1_valid_ff && advance;
   assign req_stall = !s1_load;

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff <= '{action: req_action, rtc_hour: req_rtc_hour,
                         rtc_minute: req_rtc_minute, rtc_second: req_rtc_second,
                         rtc_weekday: req_rtc_weekday, rtc_day: req_rtc_day,
                         rtc_month: req_rtc_month, rtc_year: req_rtc_year};
      end
      if (step_en) begin
         rsp_ff <= core_result;
      end
   end

   clkas_core #(
      .BLINK_HALF (BLINK_HALF)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (s1_item_ff),
      .result  (core_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_buzzer        = rsp_ff.buzzer;
   assign rsp_mode_now      = rsp_ff.mode_now;
   assign rsp_blank_field   = rsp_ff.blank_field;
   assign rsp_write_rtc     = rsp_ff.write_rtc;
   assign rsp_alarm_on      = rsp_ff.alarm_on;
   assign rsp_hour_shown    = rsp_ff.hour_shown;
   assign rsp_minute_shown  = rsp_ff.minute_shown;
   assign rsp_second_shown  = rsp_ff.second_shown;
   assign rsp_weekday_shown = rsp_ff.weekday_shown;
   assign rsp_day_shown     = rsp_ff.day_shown;
   assign rsp_month_shown   = rsp_ff.month_shown;
   assign rsp_year_shown    = rsp_ff.year_shown;

   `CLKAS_ASSERT_IMPL(a_write_leaves_setting, rsp_valid_ff && rsp_ff.write_rtc, rsp_ff.mode_now == clkas_pkg::ModeNormal)
   `CLKAS_ASSERT_IMPL(a_blank_only_setting, rsp_valid_ff && (rsp_ff.blank_field != clkas_pkg::FldNone), rsp_ff.mode_now != clkas_pkg::ModeNormal)
   `CLKAS_ASSERT_IMPL(a_alarm_field_range, rsp_valid_ff && (rsp_ff.mode_now == clkas_pkg::ModeAlarm), rsp_ff.blank_field <= clkas_pkg::AlarmLastField)
   `CLKAS_ASSERT_NEXT(a_held_word_kept, s1_valid_ff && !advance, s1_valid_ff && rsp_valid_ff)

endmodule

@@ verif/clock_alarm_checker.sv @@
module clock_alarm_checker
   import clkas_pkg::*;
#(
   parameter int unsigned BLINK_HALF = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [4:0] req_rtc_hour,
   input  logic [5:0] req_rtc_minute,
   input  logic [5:0] req_rtc_second,
   input  logic [2:0] req_rtc_weekday,
   input  logic [4:0] req_rtc_day,
   input  logic [3:0] req_rtc_month,
   input  logic [6:0] req_rtc_year,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_buzzer,
   input  logic [1:0] rsp_mode_now,
   input  logic [2:0] rsp_blank_field,
   input  logic       rsp_write_rtc,
   input  logic       rsp_alarm_on,
   input  logic [4:0] rsp_hour_shown,
   input  logic [5:0] rsp_minute_shown,
   input  logic [5:0] rsp_second_shown,
   input  logic [2:0] rsp_weekday_shown,
   input  logic [4:0] rsp_day_shown,
   input  logic [3:0] rsp_month_shown,
   input  logic [6:0] rsp_year_shown,
   output int         fail_count,
   output int         words_in_flight
);

   mode_type      mode_q;
   logic [2:0]    sel_q;
   logic [5:0]    blink_q;
   date_time_type edit_q;
   logic [4:0]    alm_hour;
   logic [5:0]    alm_minute;
   logic [5:0]    alm_second;
   logic          alm_enable;
   logic          ringing_q;

   result_type    due_results[$];
   result_type    got_word;
   result_type    want_word;
   int            mismatches;

   function automatic logic [6:0] wrapped(logic [6:0] value, logic up,
                                          logic [6:0] bottom, logic [6:0] top);
      if (up) begin
         return (value < top) ? value + 7'd1 : bottom;
      end
      return (value > bottom) ? value - 7'd1 : top;
   endfunction

   function automatic void step_clock_field(logic up);
      case (sel_q)
         FldHour: begin
            edit_q.hour = 5'(wrapped(7'(edit_q.hour), up, ZeroMin, HourMax));
         end
         FldMinute: begin
            edit_q.minute = 6'(wrapped(7'(edit_q.minute), up, ZeroMin, MinSecMax));
         end
         FldSecond: begin
            edit_q.second = 6'(wrapped(7'(edit_q.second), up, ZeroMin, MinSecMax));
         end
         FldWeekday: begin
            edit_q.weekday = 3'(wrapped(7'(edit_q.weekday), up, OneMin, WeekdayMax));
         end
         FldDay: begin
            edit_q.day = 5'(wrapped(7'(edit_q.day), up, OneMin, DayMax));
         end
         FldMonth: begin
            edit_q.month = 4'(wrapped(7'(edit_q.month), up, OneMin, MonthMax));
         end
         FldYear: begin
            edit_q.year = wrapped(edit_q.year, up, ZeroMin, YearMax);
         end
         default: ;
      endcase
   endfunction

   function automatic void step_alarm_field(logic up);
      case (sel_q)
         AlmEnable: alm_enable = !alm_enable;
         AlmHour: begin
            alm_hour = 5'(wrapped(7'(alm_hour), up, ZeroMin, HourMax));
         end
         AlmMinute: begin
            alm_minute = 6'(wrapped(7'(alm_minute), up, ZeroMin, MinSecMax));
         end
         AlmSecond: begin
            alm_second = 6'(wrapped(7'(alm_second), up, ZeroMin, MinSecMax));
         end
         default: ;
      endcase
   endfunction

   function automatic result_type next_display(item_type w);
      result_type r;
      logic [2:0] last;
      logic       write_pulse;
      write_pulse = 1'b0;
      if (mode_q != ModeNormal) begin
         last = (mode_q == ModeTime) ? TimeLastField : AlarmLastField;
         blink_q = blink_q + 6'd1;
         if (blink_q >= 2 * BLINK_HALF) blink_q = '0;
         if (w.action == ActUp || w.action == ActDown) begin
            blink_q = '0;
            if (mode_q == ModeTime) step_clock_field(w.action == ActUp);
            else step_alarm_field(w.action == ActUp);
         end else if (w.action == ActNext) begin
            blink_q = 6'(BLINK_HALF);
            sel_q = (sel_q >= last) ? FldHour : sel_q + 3'd1;
         end else if (w.action == ActTime && mode_q == ModeTime) begin
            mode_q = ModeNormal;
            write_pulse = 1'b1;
         end else if (w.action == ActAlarm && mode_q == ModeAlarm) begin
            mode_q = ModeNormal;
         end
      end else begin
         edit_q = {w.rtc_hour, w.rtc_minute, w.rtc_second, w.rtc_weekday,
                   w.rtc_day, w.rtc_month, w.rtc_year};
         // compare before the button, so an alarm press on the matching word silences at once
         if (alm_enable && w.rtc_hour == alm_hour && w.rtc_minute == alm_minute &&
             w.rtc_second == alm_second) ringing_q = 1'b1;
         if (w.action == ActTime) begin
            mode_q  = ModeTime;
            sel_q   = FldHour;
            blink_q = '0;
         end else if (w.action == ActAlarm) begin
            if (ringing_q) begin
               ringing_q = 1'b0;
            end else begin
               mode_q  = ModeAlarm;
               sel_q   = AlmEnable;
               blink_q = '0;
            end
         end
      end

      r.buzzer        = ringing_q;
      r.mode_now      = mode_q;
      r.blank_field   = (mode_q != ModeNormal && blink_q >= BLINK_HALF) ? sel_q : FldNone;
      r.write_rtc     = write_pulse;
      r.alarm_on      = alm_enable;
      r.hour_shown    = (mode_q == ModeAlarm) ? alm_hour : edit_q.hour;
      r.minute_shown  = (mode_q == ModeAlarm) ? alm_minute : edit_q.minute;
      r.second_shown  = (mode_q == ModeAlarm) ? alm_second : edit_q.second;
      r.weekday_shown = edit_q.weekday;
      r.day_shown     = edit_q.day;
      r.month_shown   = edit_q.month;
      r.year_shown    = edit_q.year;
      return r;
   endfunction

   task automatic show_word(input string tag, input result_type r);
      $display("   %s: buzzer %0d mode %0d blank %0d write %0d alarm_on %0d",
               tag, r.buzzer, r.mode_now, r.blank_field, r.write_rtc, r.alarm_on);
      $display("   %s: %0d:%0d:%0d weekday %0d date %0d/%0d/%0d", tag, r.hour_shown,
               r.minute_shown, r.second_shown, r.weekday_shown, r.day_shown,
               r.month_shown, r.year_shown);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q     = ModeNormal;
         sel_q      = FldHour;
         blink_q    = '0;
         edit_q     = {5'd0, 6'd0, 6'd0, 3'd1, 5'd1, 4'd1, 7'd0};
         alm_hour   = '0;
         alm_minute = '0;
         alm_second = '0;
         alm_enable = 1'b0;
         ringing_q  = 1'b0;
         mismatches = 0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_word = {rsp_buzzer, rsp_mode_now, rsp_blank_field, rsp_write_rtc,
                        rsp_alarm_on, rsp_hour_shown, rsp_minute_shown, rsp_second_shown,
                        rsp_weekday_shown, rsp_day_shown, rsp_month_shown, rsp_year_shown};
            if (due_results.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result word at %0t", $realtime);
                  show_word("actual", got_word);
               end
               mismatches++;
            end else begin
               want_word = due_results.pop_front();
               if (got_word !== want_word) begin
                  if (mismatches < 10) begin
                     $display("result word mismatch at %0t", $realtime);
                     show_word("expected", want_word);
                     show_word("actual", got_word);
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_results.push_back(next_display({req_action, req_rtc_hour, req_rtc_minute,
               req_rtc_second, req_rtc_weekday, req_rtc_day, req_rtc_month, req_rtc_year}));
         end
      end
      fail_count      <= mismatches;
      words_in_flight <= due_results.size();
   end

endmodule

@@ verif/tb_clock_alarm_set_controller.sv @@
module tb_clock_alarm_set_controller;
   import clkas_pkg::*;

   localparam logic [2:0] ActSpareLo = 3'd6;
   localparam logic [2:0] ActSpareHi = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_action = '0;
   logic [4:0] req_rtc_hour = '0;
   logic [5:0] req_rtc_minute = '0;
   logic [5:0] req_rtc_second = '0;
   logic [2:0] req_rtc_weekday = '0;
   logic [4:0] req_rtc_day = '0;
   logic [3:0] req_rtc_month = '0;
   logic [6:0] req_rtc_year = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_buzzer;
   logic [1:0] rsp_mode_now;
   logic [2:0] rsp_blank_field;
   logic       rsp_write_rtc;
   logic       rsp_alarm_on;
   logic [4:0] rsp_hour_shown;
   logic [5:0] rsp_minute_shown;
   logic [5:0] rsp_second_shown;
   logic [2:0] rsp_weekday_shown;
   logic [4:0] rsp_day_shown;
   logic [3:0] rsp_month_shown;
   logic [6:0] rsp_year_shown;

   logic       quiet = 1'b0;
   int         fail_count;
   int         words_in_flight;
   int         words_sent = 0;

   clock_alarm_set_controller dut (.*);

   clock_alarm_checker checker_inst (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(0, 99) < 10);
   end

   initial begin
      #(12 * 300000);
      $display("tb_clock_alarm_set_controller NOT OK");
      $finish;
   end

   function automatic item_type word_of(logic [2:0] act, int h, int m, int s, int wd,
                                        int d, int mo, int y);
      return {act, 5'(h), 6'(m), 6'(s), 3'(wd), 5'(d), 4'(mo), 7'(y)};
   endfunction

   // mostly legal clock values, some near the alarm's usual haunts, a few raw bit patterns
   function automatic item_type clock_word(logic [2:0] act);
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return word_of(act, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
      end
      if (pick < 3) begin
         return word_of(act, ($urandom_range(0, 2) == 0) ? 23 : $urandom_range(0, 1),
                        ($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 1),
                        ($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 1),
                        $urandom_range(1, 7), $urandom_range(1, 31), $urandom_range(1, 12),
                        $urandom_range(0, 99));
      end
      return word_of(act, $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                     $urandom_range(1, 7), $urandom_range(1, 31), $urandom_range(1, 12),
                     $urandom_range(0, 99));
   endfunction

   task automatic send_word(input item_type w);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_action, req_rtc_hour, req_rtc_minute, req_rtc_second, req_rtc_weekday,
       req_rtc_day, req_rtc_month, req_rtc_year} <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      quiet <= (words_sent >= 300 && words_sent < 450);
   endtask

   // drop valid and hold until every result has come back
   task automatic hold_off();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   task automatic setting_session(input logic [2:0] enter_act);
      int         steps;
      int         run;
      int         pick;
      logic [2:0] other;
      other = (enter_act == ActTime) ? ActAlarm : ActTime;
      send_word(clock_word(enter_act));
      steps = $urandom_range(1, 24);
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            send_word(clock_word(ActUp));
         end else if (pick < 52) begin
            send_word(clock_word(ActDown));
         end else if (pick < 68) begin
            send_word(clock_word(ActNext));
         end else if (pick < 88) begin
            // long runs can carry the blink counter through both halves and its wrap
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
            repeat (run) send_word(clock_word(ActPoll));
         end else begin
            pick = $urandom_range(0, 2);
            send_word(clock_word((pick == 0) ? other : (pick == 1) ? ActSpareLo : ActSpareHi));
         end
      end
      if ($urandom_range(0, 9) != 0) send_word(clock_word(enter_act));
   endtask

   initial begin
      int   pick;
      logic pressed;
      pressed = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(word_of(ActPoll, 0, 0, 0, 0, 0, 0, 0));
      send_word(word_of(ActPoll, 23, 59, 59, 7, 31, 12, 99));
      // load out-of-range values into the edit fields, then step each one; every field but the second wraps
      send_word(word_of(ActTime, 31, 63, 63, 0, 0, 0, 127));
      send_word(word_of(ActUp, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActDown, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActUp, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActDown, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActDown, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActDown, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActDown, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActUp, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActNext, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActAlarm, 0, 0, 0, 1, 1, 1, 0));
      send_word(word_of(ActTime, 0, 0, 0, 1, 1, 1, 0));
      // arm the alarm at 23:00:00, let it ring, silence it
      send_word(word_of(ActAlarm, 5, 5, 5, 2, 2, 2, 2));
      send_word(word_of(ActUp, 5, 5, 5, 2, 2, 2, 2));
      send_word(word_of(ActNext, 5, 5, 5, 2, 2, 2, 2));
      send_word(word_of(ActDown, 5, 5, 5, 2, 2, 2, 2));
      send_word(word_of(ActTime, 5, 5, 5, 2, 2, 2, 2));
      send_word(word_of(ActAlarm, 5, 5, 5, 2, 2, 2, 2));
      send_word(word_of(ActUp, 23, 0, 0, 3, 3, 3, 3));
      send_word(word_of(ActSpareHi, 23, 0, 1, 3, 3, 3, 3));
      send_word(word_of(ActAlarm, 23, 0, 2, 3, 3, 3, 3));
      hold_off();

      while (words_sent < 825) begin
         if (words_sent >= 550 && !pressed) begin
            hold_off();
            pressed = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 8)) send_word(clock_word(ActPoll));
         end else if (pick < 60) begin
            setting_session(ActTime);
         end else if (pick < 85) begin
            setting_session(ActAlarm);
         end else begin
            repeat ($urandom_range(1, 4)) send_word(clock_word(3'($urandom)));
         end
      end

      hold_off();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_clock_alarm_set_controller OK");
      end else begin
         $display("tb_clock_alarm_set_controller NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/clkas_pkg.sv
design/clkas_core.sv
design/clock_alarm_set_controller.sv
verif/clock_alarm_checker.sv
verif/tb_clock_alarm_set_controller.sv
